// ===== design/bhat_pkg.sv =====
package bhat_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned StatusW = 10;
  localparam int unsigned CfgIdxW = 2;

  // Reset values of the configuration registers.
  localparam logic [CountW-1:0] ActivityReloadRst    = 16'd6000;
  localparam logic [CountW-1:0] PressThresholdRst    = 16'd100;
  localparam logic [CountW-1:0] PoweroffThresholdRst = 16'd300;

  // Bit positions in the status word.
  localparam int unsigned BitSens1    = 0;
  localparam int unsigned BitSens2    = 1;
  localparam int unsigned BitRing     = 2;
  localparam int unsigned BitCharge   = 3;
  localparam int unsigned BitUsb5v    = 4;
  localparam int unsigned BitUsbId    = 5;
  localparam int unsigned BitSw1Held  = 6;
  localparam int unsigned BitSw2Held  = 7;
  localparam int unsigned BitGpsTime  = 8;
  localparam int unsigned BitGpsPower = 9;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ACTIVITY_RELOAD    = 2'd0,
    REG_PRESS_THRESHOLD    = 2'd1,
    REG_POWEROFF_THRESHOLD = 2'd2
  } bhat_reg_e;

  // Result of one switch hold evaluation.
  typedef struct packed {
    logic              held;
    logic              accept;
    logic [CountW-1:0] count;
  } bhat_hold_t;

endpackage

// ===== design/bhat_in_if.sv =====
interface bhat_in_if;
  logic valid;
  logic ready;
  logic sensor_one;
  logic sensor_two;
  logic ring_line;
  logic charge_status;
  logic usb_power;
  logic usb_ident;
  logic gps_pulse;
  logic gps_powered;
  logic switch_one;
  logic switch_two;
  logic gps_enabled;

  modport source (
    output valid, sensor_one, sensor_two, ring_line, charge_status, usb_power,
           usb_ident, gps_pulse, gps_powered, switch_one, switch_two, gps_enabled,
    input  ready
  );
  modport sink (
    input  valid, sensor_one, sensor_two, ring_line, charge_status, usb_power,
           usb_ident, gps_pulse, gps_powered, switch_one, switch_two, gps_enabled,
    output ready
  );
endinterface

// ===== design/bhat_out_if.sv =====
interface bhat_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  status_word;
  logic [15:0] activity_left;
  logic        sleep_event;
  logic        modem_on_pulse;
  logic        gps_on_pulse;
  logic        gps_off_pulse;
  logic        power_off_request;

  modport source (
    output valid, status_word, activity_left, sleep_event, modem_on_pulse,
           gps_on_pulse, gps_off_pulse, power_off_request,
    input  ready
  );
  modport sink (
    input  valid, status_word, activity_left, sleep_event, modem_on_pulse,
           gps_on_pulse, gps_off_pulse, power_off_request,
    output ready
  );
endinterface

// ===== design/button_hold_and_activity_timer_core.sv =====
// Channel   Direction  Handshake          Payload
// in_i      sink       valid/ready        eleven sampled pin levels, one tick each
// out_o     source     valid/ready        status word, countdown, five event flags
// cfg_*     input      write enable only  register index and 16-bit data
//
// The state update and the result of each tick are formed by short logic in the
// cycle that accepts the transaction, and the result is registered. A new
// transaction is accepted every cycle while the output register is empty or
// being drained, so the sustained rate is one per clock.
// Reset (rst_ni, asynchronous, active low) clears the status word and the hold
// counters, loads the countdown with 6000 and the registers with their defaults.
// A stalled output holds its result and stops intake until it is taken.
module button_hold_and_activity_timer_core import bhat_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CountW-1:0]  cfg_data_i,
  bhat_in_if.sink            in_i,
  bhat_out_if.source         out_o
);

  // Configuration registers.
  logic [CountW-1:0] activity_reload_q;
  logic [CountW-1:0] press_threshold_q;
  logic [CountW-1:0] poweroff_threshold_q;

  // Tick state.
  logic [StatusW-1:0] levels_q;
  logic [StatusW-1:0] levels_d;
  logic [CountW-1:0]  activity_q;
  logic [CountW-1:0]  activity_d;
  logic [CountW-1:0]  activity_base;
  logic [CountW-1:0]  activity_dec;
  logic               activity_seen;
  logic               sleep_d;

  // Output register.
  logic               out_valid_q;
  logic [StatusW-1:0] status_q;
  logic [CountW-1:0]  activity_left_q;
  logic               sleep_q;
  logic               modem_q;
  logic               gps_on_q;
  logic               gps_off_q;
  logic               power_off_q;

  logic       accept;
  bhat_hold_t hold_one;
  bhat_hold_t hold_two;

  // The output register accepts a new result when empty or when its current
  // transaction completes in this cycle.
  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      activity_reload_q    <= ActivityReloadRst;
      press_threshold_q    <= PressThresholdRst;
      poweroff_threshold_q <= PoweroffThresholdRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ACTIVITY_RELOAD:    activity_reload_q    <= cfg_data_i;
        REG_PRESS_THRESHOLD:    press_threshold_q    <= cfg_data_i;
        REG_POWEROFF_THRESHOLD: poweroff_threshold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Switch one is active high, switch two active low.
  bhat_hold u_hold_one (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (accept),
    .pressed_i   (in_i.switch_one),
    .held_i      (levels_q[BitSw1Held]),
    .threshold_i (press_threshold_q),
    .hold_o      (hold_one)
  );

  bhat_hold u_hold_two (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (accept),
    .pressed_i   (~in_i.switch_two),
    .held_i      (levels_q[BitSw2Held]),
    .threshold_i (press_threshold_q),
    .hold_o      (hold_two)
  );

  always_comb begin
    // A change on either sensor or on the ring line counts as activity. The
    // status word takes eight pin levels as new samples, plus the held flags
    // of the two switch hold units.
    activity_seen = (levels_q[BitSens1] != in_i.sensor_one) |
                    (levels_q[BitSens2] != in_i.sensor_two) |
                    (levels_q[BitRing]  != in_i.ring_line);

    levels_d              = '0;
    levels_d[BitSens1]    = in_i.sensor_one;
    levels_d[BitSens2]    = in_i.sensor_two;
    levels_d[BitRing]     = in_i.ring_line;
    levels_d[BitCharge]   = in_i.charge_status;
    levels_d[BitUsb5v]    = in_i.usb_power;
    levels_d[BitUsbId]    = in_i.usb_ident;
    levels_d[BitSw1Held]  = hold_one.held;
    levels_d[BitSw2Held]  = hold_two.held;
    levels_d[BitGpsTime]  = in_i.gps_pulse;
    levels_d[BitGpsPower] = in_i.gps_powered;

    // The countdown is reloaded on activity, then always decremented; reaching
    // zero reloads it again and signals sleep. A zero reload wraps instead.
    activity_base = activity_seen ? activity_reload_q : activity_q;
    activity_dec  = activity_base - 1'b1;
    sleep_d       = (activity_dec == '0);
    activity_d    = sleep_d ? activity_reload_q : activity_dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q   <= '0;
      activity_q <= ActivityReloadRst;
    end else if (accept) begin
      levels_q   <= levels_d;
      activity_q <= activity_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  // Result payload; loaded only with an accepted transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q        <= levels_d;
      activity_left_q <= activity_d;
      sleep_q         <= sleep_d;
      modem_q         <= hold_one.accept;
      gps_on_q        <= hold_two.accept & ~in_i.gps_enabled;
      gps_off_q       <= hold_two.accept & in_i.gps_enabled;
      power_off_q     <= hold_two.count > poweroff_threshold_q;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.status_word       = status_q;
  assign out_o.activity_left     = activity_left_q;
  assign out_o.sleep_event       = sleep_q;
  assign out_o.modem_on_pulse    = modem_q;
  assign out_o.gps_on_pulse      = gps_on_q;
  assign out_o.gps_off_pulse     = gps_off_q;
  assign out_o.power_off_request = power_off_q;

endmodule

// ===== design/bhat_hold.sv =====
module bhat_hold import bhat_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              pressed_i,
  input  logic              held_i,
  input  logic [CountW-1:0] threshold_i,
  output bhat_hold_t        hold_o
);

  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_d;
  logic              held_base;

  // The hold counter saturates at all ones and clears on release.
  always_comb begin
    if (pressed_i) begin
      count_d = (count_q == {CountW{1'b1}}) ? count_q : count_q + 1'b1;
    end else begin
      count_d = '0;
    end
    held_base     = pressed_i & held_i;
    hold_o.count  = count_d;
    hold_o.accept = (count_d > threshold_i) & ~held_base;
    hold_o.held   = held_base | hold_o.accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (en_i) begin
      count_q <= count_d;
    end
  end

endmodule
